// ===== design/clcd_pkg.sv =====
// Shared types, constants and helper functions for the character LCD interface.
package clcd_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TICK_W     = 8;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned PINS_W     = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE     = 3'd4;

    localparam logic [7:0] RST_POWER_UP  = 8'd15;
    localparam logic [7:0] RST_FIRST_GAP = 8'd4;
    localparam logic [7:0] RST_SHORT_GAP = 8'd1;
    localparam logic [7:0] RST_READ      = 8'd1;
    localparam logic [7:0] RST_WRITE     = 8'd1;

    typedef logic [2:0] t_phase;

    localparam t_phase PH_POWER = 3'd0;
    localparam t_phase PH_READ  = 3'd1;
    localparam t_phase PH_RGAP  = 3'd2;
    localparam t_phase PH_WRITE = 3'd3;
    localparam t_phase PH_GAP   = 3'd4;
    localparam t_phase PH_IDLE  = 3'd5;

    localparam logic [STEP_W-1:0] STEP_LAST_WAKE = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LAST_CMD  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DONE      = 4'd8;

    localparam int unsigned PIN_RS    = 8;
    localparam int unsigned PIN_RW    = 9;
    localparam int unsigned PIN_E     = 10;
    localparam int unsigned PIN_DRIVE = 11;

    typedef struct packed {
        logic [7:0] power_up_ticks;
        logic [7:0] first_gap_ticks;
        logic [7:0] short_gap_ticks;
        logic [7:0] read_ticks;
        logic [7:0] write_ticks;
    } t_cfg;

    typedef struct packed {
        logic       req_valid;
        logic       req_is_data;
        logic [7:0] req_byte;
        logic       busy_in;
    } t_req;

    typedef struct packed {
        logic       rs_pin;
        logic       rw_pin;
        logic       enable_pin;
        logic [7:0] bus_byte;
        logic       bus_drive;
        logic       req_taken;
        logic       ready_res;
    } t_res;

    function automatic logic [7:0] f_init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0, 3'd1, 3'd2: b = 8'h30;
            3'd3: b = 8'h38;
            3'd4: b = 8'h10;
            3'd5: b = 8'h06;
            3'd6: b = 8'h01;
            default: b = 8'h0F;
        endcase
        return b;
    endfunction

    function automatic logic f_span_last(input logic [TICK_W-1:0] count,
                                         input logic [TICK_W-1:0] n);
        return ({1'b0, count} + {{TICK_W{1'b0}}, 1'b1}) >= {1'b0, n};
    endfunction

    function automatic logic [PINS_W-1:0] f_pins(input t_phase ph,
                                                 input logic [7:0] held,
                                                 input logic is_data);
        logic [PINS_W-1:0] idle;
        logic [PINS_W-1:0] p;
        idle = '0;
        idle[7:0] = held;
        idle[PIN_RS] = is_data;
        idle[PIN_DRIVE] = 1'b1;
        p = '0;
        unique case (ph)
            PH_READ: begin
                p[PIN_RW] = 1'b1;
                p[PIN_E] = 1'b1;
            end
            PH_RGAP: begin
                p[PIN_RW] = 1'b1;
            end
            PH_WRITE: begin
                p = idle;
                p[PIN_E] = 1'b1;
            end
            default: p = idle;
        endcase
        return p;
    endfunction

endpackage

// ===== design/clcd_req_if.sv =====
// Request channel: one word per tick with the request and busy flag level.
interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic       req_valid;
    logic       req_is_data;
    logic [7:0] req_byte;
    logic       busy_in;

    modport source (output valid, output req_valid, output req_is_data,
                    output req_byte, output busy_in, input ready);
    modport sink (input valid, input req_valid, input req_is_data,
                  input req_byte, input busy_in, output ready);
endinterface

// ===== design/clcd_res_if.sv =====
// Result channel: pin levels and status for one tick.
interface clcd_res_if;
    logic       valid;
    logic       ready;
    logic       rs_pin;
    logic       rw_pin;
    logic       enable_pin;
    logic [7:0] bus_byte;
    logic       bus_drive;
    logic       req_taken;
    logic       ready_res;

    modport source (output valid, output rs_pin, output rw_pin, output enable_pin,
                    output bus_byte, output bus_drive, output req_taken,
                    output ready_res, input ready);
    modport sink (input valid, input rs_pin, input rw_pin, input enable_pin,
                  input bus_byte, input bus_drive, input req_taken,
                  input ready_res, output ready);
endinterface

// ===== design/clcd_cfg.sv =====
// Timing configuration registers for the character LCD interface.
module clcd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    output clcd_pkg::t_cfg                o_cfg
);
    import clcd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_up_ticks  <= RST_POWER_UP;
            r_cfg.first_gap_ticks <= RST_FIRST_GAP;
            r_cfg.short_gap_ticks <= RST_SHORT_GAP;
            r_cfg.read_ticks      <= RST_READ;
            r_cfg.write_ticks     <= RST_WRITE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POWER_UP:  r_cfg.power_up_ticks  <= i_cfg_data;
                CFG_FIRST_GAP: r_cfg.first_gap_ticks <= i_cfg_data;
                CFG_SHORT_GAP: r_cfg.short_gap_ticks <= i_cfg_data;
                CFG_READ:      r_cfg.read_ticks      <= i_cfg_data;
                CFG_WRITE:     r_cfg.write_ticks     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== design/clcd_seq.sv =====
// Init and transfer sequencer: state registers and per-tick result word.
module clcd_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  clcd_pkg::t_req i_word,
    input  clcd_pkg::t_cfg i_cfg,
    output clcd_pkg::t_res o_res
);
    import clcd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [7:0]          r_held, n_held;
    logic                r_is_data, n_is_data;
    logic [PINS_W-1:0]   r_pins, n_pins;
    logic                taken;
    logic [STEP_W-1:0]   step_inc;
    logic [TICK_W-1:0]   tick_inc;
    logic [TICK_W-1:0]   gap_ticks;

    assign step_inc  = r_step + 4'd1;
    assign tick_inc  = r_tick + 8'd1;
    assign gap_ticks = (r_step == '0) ? i_cfg.first_gap_ticks : i_cfg.short_gap_ticks;

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_step    = r_step;
        n_held    = r_held;
        n_is_data = r_is_data;
        taken     = 1'b0;
        unique case (r_phase)
            PH_POWER: begin
                if (f_span_last(r_tick, i_cfg.power_up_ticks)) begin
                    n_step    = '0;
                    n_held    = f_init_byte(3'd0);
                    n_is_data = 1'b0;
                    n_phase   = PH_READ;
                    n_tick    = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            PH_READ: begin
                if (f_span_last(r_tick, i_cfg.read_ticks)) begin
                    n_tick  = '0;
                    n_phase = i_word.busy_in ? PH_RGAP : PH_WRITE;
                end else begin
                    n_tick = tick_inc;
                end
            end
            PH_RGAP: begin
                n_phase = PH_READ;
                n_tick  = '0;
            end
            PH_WRITE: begin
                if (f_span_last(r_tick, i_cfg.write_ticks)) begin
                    n_tick = '0;
                    if (r_step <= STEP_LAST_WAKE) begin
                        n_phase = PH_GAP;
                    end else if (r_step < STEP_LAST_CMD) begin
                        n_step    = step_inc;
                        n_held    = f_init_byte(step_inc[2:0]);
                        n_is_data = 1'b0;
                        n_phase   = PH_READ;
                    end else begin
                        n_step  = STEP_DONE;
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end
            PH_GAP: begin
                if (f_span_last(r_tick, gap_ticks)) begin
                    n_step    = step_inc;
                    n_held    = f_init_byte(step_inc[2:0]);
                    n_is_data = 1'b0;
                    n_phase   = PH_READ;
                    n_tick    = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            PH_IDLE: begin
                if (i_word.req_valid) begin
                    taken     = 1'b1;
                    n_held    = i_word.req_byte;
                    n_is_data = i_word.req_is_data;
                    n_phase   = PH_READ;
                    n_tick    = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase
        n_pins = f_pins(n_phase, n_held, n_is_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_POWER;
            r_tick    <= '0;
            r_step    <= '0;
            r_held    <= '0;
            r_is_data <= 1'b0;
            r_pins    <= f_pins(PH_POWER, 8'h00, 1'b0);
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_step    <= n_step;
            r_held    <= n_held;
            r_is_data <= n_is_data;
            r_pins    <= n_pins;
        end
    end

    always_comb begin
        o_res.rs_pin     = r_pins[PIN_RS];
        o_res.rw_pin     = r_pins[PIN_RW];
        o_res.enable_pin = r_pins[PIN_E];
        o_res.bus_byte   = r_pins[7:0];
        o_res.bus_drive  = r_pins[PIN_DRIVE];
        o_res.req_taken  = taken;
        o_res.ready_res  = (r_phase == PH_IDLE);
    end

`ifndef SYNTHESIS
    a_pins_track_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pins == f_pins(r_phase, r_held, r_is_data))
        else $error("pin levels out of step with phase");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_DONE)
        else $error("init step beyond done");

    a_take_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_IDLE && i_word.req_valid) |=> (r_phase == PH_READ))
        else $error("accepted request did not start busy poll");

    a_idle_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_step == STEP_DONE))
        else $error("idle before init sequence finished");
`endif
endmodule

// ===== design/char_lcd_parallel_interface.sv =====
// Top level of the 8-bit character LCD interface: handshake and result register.
// The result word for a tick is registered and appears in the cycle after that tick is accepted.
// Throughput: one tick word per cycle while results drain; a new word is taken as the held one leaves.
// Stalls come only from the result register when its word has not been taken.
// Reset (synchronous, active low) restores default timing and restarts the power-up wait.
module char_lcd_parallel_interface (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    clcd_req_if.sink                       i_req,
    clcd_res_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data
);
    import clcd_pkg::*;

    t_cfg cfg;
    t_req word;
    t_res res;
    t_res r_res;
    logic r_out_valid;
    logic step;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign step        = i_req.valid && i_req.ready;

    always_comb begin
        word.req_valid   = i_req.req_valid;
        word.req_is_data = i_req.req_is_data;
        word.req_byte    = i_req.req_byte;
        word.busy_in     = i_req.busy_in;
    end

    clcd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    clcd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (word),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.rs_pin     = r_res.rs_pin;
    assign o_res.rw_pin     = r_res.rw_pin;
    assign o_res.enable_pin = r_res.enable_pin;
    assign o_res.bus_byte   = r_res.bus_byte;
    assign o_res.bus_drive  = r_res.bus_drive;
    assign o_res.req_taken  = r_res.req_taken;
    assign o_res.ready_res  = r_res.ready_res;

`ifndef SYNTHESIS
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !i_req.ready)
        else $error("word taken while result stalled");

    a_valid_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result missing after accepted word");

    a_drop_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_res.ready && !step) |=> !r_out_valid)
        else $error("result repeated after being taken");
`endif
endmodule
